// File: src/sipf_pkg.sv
// Shared types and constants for the servo instruction packet framer.
package sipf_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] BCAST_ID   = 8'hFE;
    localparam logic [7:0] SYNC_INSTR = 8'h83;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // One unit of work for the back end: a whole header or one parameter byte,
    // with the checksum already worked out when the job closes the packet.
    typedef struct packed {
        logic       is_start;
        logic       sync;
        logic       last;
        logic [7:0] b_id;
        logic [7:0] b_len;
        logic [7:0] b_ins;
        logic [7:0] b_op;
        logic [7:0] b_plen;
        logic [7:0] chk;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

endpackage

// File: src/sipf_front.sv
// Front end: accepts beats, tracks the open packet and the running sum, queues jobs.
module sipf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic              sync_mode,
    input  logic [7:0]        servo_id,
    input  logic [7:0]        instr_byte,
    input  logic [7:0]        target_address,
    input  logic [7:0]        per_device_length,
    input  logic [7:0]        param_count,
    input  logic [7:0]        data_byte,
    input  logic              q_full,
    output sipf_pkg::push_t   push
);

    logic       open_reg, open_next;
    logic [7:0] remain_reg, remain_next;
    logic [7:0] sum_reg, sum_next;
    logic       accept;
    logic [7:0] len_b, id_b, ins_b, op_b, plen_add, hdr_sum, data_sum;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign len_b    = sync_mode ? param_count + 8'd4 : param_count + 8'd3;
    assign id_b     = sync_mode ? sipf_pkg::BCAST_ID : servo_id;
    assign ins_b    = sync_mode ? sipf_pkg::SYNC_INSTR : instr_byte;
    assign op_b     = sync_mode ? instr_byte : target_address;
    assign plen_add = sync_mode ? per_device_length : 8'd0;
    assign hdr_sum  = id_b + len_b + ins_b + op_b + plen_add;
    assign data_sum = sum_reg + data_byte;

    always_comb
    begin
        open_next   = open_reg;
        remain_next = remain_reg;
        sum_next    = sum_reg;
        push.valid        = 1'b0;
        push.job.is_start = 1'b0;
        push.job.sync     = sync_mode;
        push.job.last     = 1'b0;
        push.job.b_id     = id_b;
        push.job.b_len    = len_b;
        push.job.b_ins    = ins_b;
        push.job.b_op     = op_b;
        push.job.b_plen   = per_device_length;
        push.job.chk      = ~hdr_sum;
        if (accept)
        begin
            if (cmd == sipf_pkg::CMD_START)
            begin
                push.valid        = 1'b1;
                push.job.is_start = 1'b1;
                push.job.last     = (param_count == 8'd0);
                open_next         = (param_count != 8'd0);
                remain_next       = param_count;
                sum_next          = hdr_sum;
            end
            else if (open_reg)
            begin
                push.valid    = 1'b1;
                push.job.b_id = data_byte;
                push.job.chk  = ~data_sum;
                push.job.last = (remain_reg == 8'd1);
                remain_next   = remain_reg - 8'd1;
                open_next     = (remain_reg != 8'd1);
                sum_next      = data_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= 8'd0;
            sum_reg    <= 8'd0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
            sum_reg    <= sum_next;
        end
    end

    a_closed_means_no_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> remain_reg == 8'd0)
        else $error("packet closed with parameter bytes still expected");

endmodule

// File: src/sipf_queue.sv
// Short job queue that decouples the front end from the byte sequencer.
module sipf_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  sipf_pkg::push_t push,
    output logic            full,
    output sipf_pkg::head_t head,
    input  logic            pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sipf_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push.valid && !full;
    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue count beyond depth");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("job popped from an empty queue");

endmodule

// File: src/sipf_back.sv
// Back end: expands each queued job into output bytes through an output register.
module sipf_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  sipf_pkg::head_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            is_checksum
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       chk_reg, chk_next;
    logic [2:0] pay_n;
    logic [2:0] last_idx;
    logic       load;
    logic [7:0] pay_byte;

    // Header jobs carry six bytes (seven in sync mode); data jobs carry one.
    assign pay_n    = head.job.is_start ? (head.job.sync ? 3'd7 : 3'd6) : 3'd1;
    assign last_idx = pay_n - 3'd1 + {2'b00, head.job.last};
    assign load     = head.valid && (!valid_reg || out_ready);
    assign pop      = load && (idx_reg == last_idx);

    always_comb
    begin
        case (idx_reg)
            3'd0:    pay_byte = head.job.is_start ? sipf_pkg::HDR_BYTE : head.job.b_id;
            3'd1:    pay_byte = sipf_pkg::HDR_BYTE;
            3'd2:    pay_byte = head.job.b_id;
            3'd3:    pay_byte = head.job.b_len;
            3'd4:    pay_byte = head.job.b_ins;
            3'd5:    pay_byte = head.job.b_op;
            default: pay_byte = head.job.b_plen;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        chk_next   = chk_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            if (idx_reg == pay_n)
            begin
                byte_next = head.job.chk;
                chk_next  = 1'b1;
            end
            else
            begin
                byte_next = pay_byte;
                chk_next  = 1'b0;
            end
            idx_next = pop ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        chk_reg  <= chk_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign is_checksum = chk_reg;

    a_mid_job_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 3'd0 |-> head.valid)
        else $error("sequencer mid-job with no job at the queue head");

endmodule

// File: src/servo_instruction_packet_framer_core.sv
// Top level of the servo instruction packet framer: front end, job queue, byte sequencer.
// The first output byte of an item passes through the job queue and then the output register.
// Throughput: one parameter beat per cycle while the job queue is not full; a start beat
// expands into six to eight output bytes, and the closing parameter beat into two (byte plus checksum).
// The job queue of QUEUE_DEPTH entries absorbs header bursts while beats keep arriving.
// Reset (rst_n low, asynchronous) closes any open packet and empties the queue and output.
module servo_instruction_packet_framer_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic       sync_mode,
    input  logic [7:0] servo_id,
    input  logic [7:0] instr_byte,
    input  logic [7:0] target_address,
    input  logic [7:0] per_device_length,
    input  logic [7:0] param_count,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_checksum
);

    sipf_pkg::push_t push;
    sipf_pkg::head_t head;
    logic            q_full;
    logic            pop;

    sipf_front u_front
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .sync_mode         (sync_mode),
        .servo_id          (servo_id),
        .instr_byte        (instr_byte),
        .target_address    (target_address),
        .per_device_length (per_device_length),
        .param_count       (param_count),
        .data_byte         (data_byte),
        .q_full            (q_full),
        .push              (push)
    );

    sipf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    sipf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_checksum (is_checksum)
    );

endmodule

// File: tb/tb_servo_instruction_packet_framer_core.sv
// Self-checking testbench for the servo instruction packet framer: directed table, then random packets.
module tb_servo_instruction_packet_framer_core;

    localparam int NUM_DIRECTED = 26;
    localparam int BEATS_PER_PHASE = 28;

    // Field order matches the port order used when a beat is driven.
    typedef struct packed {
        logic       cmd;
        logic       sync_mode;
        logic [7:0] servo_id;
        logic [7:0] instr_byte;
        logic [7:0] target_address;
        logic [7:0] per_device_length;
        logic [7:0] param_count;
        logic [7:0] data_byte;
    } beat_t;

    typedef struct packed {
        logic [7:0] value;
        logic       is_chk;
    } wire_byte_t;

    // A row either carries its wire bytes typed in (first byte in the top bits)
    // or leaves them to the framing model.
    typedef struct packed {
        beat_t       beat;
        logic        typed;
        logic [3:0]  n_typed;
        logic [63:0] typed_bytes;
        logic        chk_last;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic       sync_mode;
    logic [7:0] servo_id;
    logic [7:0] instr_byte;
    logic [7:0] target_address;
    logic [7:0] per_device_length;
    logic [7:0] param_count;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       is_checksum;

    servo_instruction_packet_framer_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .sync_mode         (sync_mode),
        .servo_id          (servo_id),
        .instr_byte        (instr_byte),
        .target_address    (target_address),
        .per_device_length (per_device_length),
        .param_count       (param_count),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .is_checksum       (is_checksum)
    );

    // Framing model state.
    logic       pkt_open;
    logic [7:0] params_left;
    logic [7:0] run_sum;

    wire_byte_t framed_now [$];
    wire_byte_t bytes_due [$];
    wire_byte_t due_byte;

    int in_idle_pct;
    int out_stall_pct;
    int beats_counted;
    int mismatch_count;

    dir_row_t directed_rows [NUM_DIRECTED] = '{
        // Parameter byte straight after reset is dropped.
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5},
          1'b1, 4'd0, 64'h0, 1'b0},
        // Normal packet, all header fields zero, no parameters.
        '{'{sipf_pkg::CMD_START, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          1'b1, 4'd7, 64'hFFFF_0003_0000_FC00, 1'b1},
        // Normal packet, all fields at their maximum; length wraps to 02.
        '{'{sipf_pkg::CMD_START, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b1, 4'd6, 64'hFFFF_FF02_FFFF_0000, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
          1'b0, 4'd0, 64'h0, 1'b0},
        // Sync start abandons the open packet and closes at once.
        '{'{sipf_pkg::CMD_START, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          1'b1, 4'd8, 64'hFFFF_FE04_8300_007A, 1'b1},
        // Parameter byte with no open packet, every other field set.
        '{'{sipf_pkg::CMD_DATA, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00},
          1'b1, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_START, 1'b1, 8'h3C, 8'hFF, 8'h5A, 8'hFF, 8'h01, 8'h00},
          1'b1, 4'd7, 64'hFFFF_FE05_83FF_FF00, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
          1'b1, 4'd2, 64'hFF7C_0000_0000_0000, 1'b1},
        '{'{sipf_pkg::CMD_START, 1'b0, 8'h01, 8'h03, 8'h1E, 8'h77, 8'h02, 8'h99},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b1, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hFF},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_START, 1'b0, 8'hFE, 8'h03, 8'h20, 8'h00, 8'h01, 8'h00},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80},
          1'b0, 4'd0, 64'h0, 1'b0},
        // Length byte wraps to zero, then the packet is abandoned.
        '{'{sipf_pkg::CMD_START, 1'b0, 8'h07, 8'h02, 8'h24, 8'h00, 8'hFD, 8'h00},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_START, 1'b0, 8'h01, 8'h01, 8'h00, 8'h00, 8'hFC, 8'h00},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_START, 1'b1, 8'hAA, 8'h1E, 8'h55, 8'h04, 8'hFC, 8'hC3},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h34},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h56},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_START, 1'b0, 8'h01, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_START, 1'b1, 8'h00, 8'h1E, 8'h00, 8'h04, 8'h04, 8'h00},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b1, 8'hC1, 8'h5E, 8'hA7, 8'h3B, 8'h6D, 8'h01},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h2F, 8'h90, 8'h44, 8'hE8, 8'h13, 8'h02},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b1, 8'h7A, 8'h0C, 8'hD9, 8'h61, 8'hB2, 8'h03},
          1'b0, 4'd0, 64'h0, 1'b0},
        '{'{sipf_pkg::CMD_DATA, 1'b0, 8'h85, 8'hF3, 8'h1A, 8'h9C, 8'h40, 8'h04},
          1'b0, 4'd0, 64'h0, 1'b0}
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function void put_wire(input logic [7:0] value, input bit summed);
        framed_now.push_back('{value, 1'b0});
        if (summed)
            run_sum = run_sum + value;
    endfunction

    function void close_packet();
        framed_now.push_back('{~run_sum, 1'b1});
        pkt_open = 1'b0;
        params_left = 8'h00;
    endfunction

    // Works out the wire bytes that one accepted beat causes.
    function void frame_beat(input beat_t b);
        framed_now.delete();
        if (b.cmd == sipf_pkg::CMD_START)
        begin
            run_sum = 8'h00;
            put_wire(sipf_pkg::HDR_BYTE, 1'b0);
            put_wire(sipf_pkg::HDR_BYTE, 1'b0);
            if (b.sync_mode)
            begin
                put_wire(sipf_pkg::BCAST_ID, 1'b1);
                put_wire(8'(b.param_count + 8'd4), 1'b1);
                put_wire(sipf_pkg::SYNC_INSTR, 1'b1);
                put_wire(b.instr_byte, 1'b1);
                put_wire(b.per_device_length, 1'b1);
            end
            else
            begin
                put_wire(b.servo_id, 1'b1);
                put_wire(8'(b.param_count + 8'd3), 1'b1);
                put_wire(b.instr_byte, 1'b1);
                put_wire(b.target_address, 1'b1);
            end
            if (b.param_count == 8'h00)
                close_packet();
            else
            begin
                pkt_open = 1'b1;
                params_left = b.param_count;
            end
        end
        else if (pkt_open)
        begin
            put_wire(b.data_byte, 1'b1);
            params_left = params_left - 8'd1;
            if (params_left == 8'h00)
                close_packet();
        end
    endfunction

    function beat_t random_beat(input logic kind);
        beat_t b;
        b.cmd = kind;
        b.sync_mode = 1'($urandom_range(0, 1));
        b.servo_id = 8'($urandom);
        b.instr_byte = 8'($urandom);
        b.target_address = 8'($urandom);
        b.per_device_length = 8'($urandom);
        b.param_count = 8'($urandom);
        b.data_byte = 8'($urandom);
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input beat_t b, input logic typed, input int n_typed,
                             input logic [63:0] typed_bytes, input logic chk_last);
        int k;
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {cmd, sync_mode, servo_id, instr_byte, target_address, per_device_length,
         param_count, data_byte} = b;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        frame_beat(b);
        if (framed_now.size() != 0)
            beats_counted++;
        if (typed)
        begin
            for (k = 0; k < n_typed; k++)
                bytes_due.push_back('{typed_bytes[63 - 8 * k -: 8],
                                     chk_last && (k == n_typed - 1)});
        end
        else
        begin
            for (k = 0; k < framed_now.size(); k++)
                bytes_due.push_back(framed_now[k]);
        end
        @(negedge clk);
    endtask

    task automatic send_params(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_beat(random_beat(sipf_pkg::CMD_DATA), 1'b0, 0, 64'h0, 1'b0);
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bytes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output beat: byte %02h checksum %0b",
                             out_byte, is_checksum);
            end
            else
            begin
                due_byte = bytes_due.pop_front();
                if (out_byte !== due_byte.value || is_checksum !== due_byte.is_chk)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("output mismatch: expected %02h/%0b, got %02h/%0b",
                                 due_byte.value, due_byte.is_chk, out_byte, is_checksum);
                end
            end
        end
    end

    initial
    begin
        int phase;
        int goal;
        int pick;
        int cnt;
        int row;
        beat_t b;

        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {cmd, sync_mode, servo_id, instr_byte, target_address, per_device_length,
         param_count, data_byte} = '0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        beats_counted = 0;
        mismatch_count = 0;
        pkt_open = 1'b0;
        params_left = 8'h00;
        run_sum = 8'h00;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (row = 0; row < NUM_DIRECTED; row++)
            send_beat(directed_rows[row].beat, directed_rows[row].typed,
                      directed_rows[row].n_typed, directed_rows[row].typed_bytes,
                      directed_rows[row].chk_last);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 74; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 74; end
                default: begin in_idle_pct = 25; out_stall_pct = 25; end
            endcase
            goal = beats_counted + BEATS_PER_PHASE;
            while (beats_counted < goal)
            begin
                pick = $urandom_range(0, 99);
                b = random_beat(sipf_pkg::CMD_START);
                if (pick < 78)
                begin
                    // Complete packet, mostly with a short parameter list.
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        cnt = 0;
                    else if (pick < 90)
                        cnt = $urandom_range(1, 8);
                    else
                        cnt = $urandom_range(9, 40);
                    b.param_count = 8'(cnt);
                    send_beat(b, 1'b0, 0, 64'h0, 1'b0);
                    send_params(cnt);
                end
                else if (pick < 90)
                begin
                    // Packet cut short; the next start abandons it.
                    cnt = b.param_count;
                    send_beat(b, 1'b0, 0, 64'h0, 1'b0);
                    send_params((cnt > 3) ? $urandom_range(0, 3) : 0);
                end
                else
                    send_params($urandom_range(1, 3));
            end
        end

        in_valid = 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: servo_instruction_packet_framer_core.f
src/sipf_pkg.sv
src/sipf_front.sv
src/sipf_queue.sv
src/sipf_back.sv
src/servo_instruction_packet_framer_core.sv
tb/tb_servo_instruction_packet_framer_core.sv
